[hw/rtl/csc_pkg.sv]
// Shared types, constants and the rpm lookup table for the cruise setpoint controller.
`default_nettype none

package csc_pkg;

	// Field widths fixed by the item layout.
	localparam int PedalW    = 10;
	localparam int SetpointW = 7;
	localparam int RpmW      = 11;
	localparam int TimeW     = 32;
	localparam int IntervalW = 16;
	localparam int StepW     = 5;
	localparam int CfgDataW  = 16;
	localparam int CfgIndexW = 1;
	localparam int InDataW   = 48;
	localparam int OutDataW  = 16;

	// Speed scale: pedal full scale maps to the top speed.
	localparam int SpeedMax  = 120;

	// Speed to rpm ratio as an exact fraction.
	localparam longint unsigned RpmNum = 64'd1291490549;
	localparam longint unsigned RpmDen = 64'd100000000;

	// Register reset values.
	localparam logic [IntervalW-1:0] IntervalReset = 16'd50;
	localparam logic [StepW-1:0]     StepReset     = 5'd5;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] RegSendInterval = 1'd0;
	localparam logic [CfgIndexW-1:0] RegSpeedStep    = 1'd1;

	// One input beat.
	typedef struct packed {
		logic [TimeW-1:0]  now_ms;
		logic              minus_button;
		logic              plus_button;
		logic              cruise_button;
		logic              brake_pressed;
		logic [PedalW-1:0] pedal_sample;
	} csc_in_t;

	// One result beat.
	typedef struct packed {
		logic            frame_brake;
		logic            frame_cruise;
		logic [RpmW-1:0] frame_rpm;
		logic            send_frame;
		logic            brake_lamp;
		logic            cruise_lamp;
	} csc_result_t;

	// Controller state carried from one tick to the next.
	typedef struct packed {
		logic                 brake_prev;
		logic                 cruise_prev;
		logic                 plus_prev;
		logic                 minus_prev;
		logic                 cruise_on;
		logic                 brake_latched;
		logic [SetpointW-1:0] setpoint;
		logic [TimeW-1:0]     last_send_ms;
	} csc_state_t;

	// Configuration values as seen by the update logic.
	typedef struct packed {
		logic [IntervalW-1:0] send_interval_ms;
		logic [StepW-1:0]     speed_step;
	} csc_cfg_t;

	typedef logic [RpmW-1:0] rpm_table_t [0:(1<<SetpointW)-1];

	// Table of floor(setpoint * ratio); entries above the top speed are never read.
	function automatic rpm_table_t build_rpm_table();
		rpm_table_t t;
		for (int i = 0; i < (1 << SetpointW); i++) begin
			if (i <= SpeedMax) begin
				t[i] = RpmW'((longint'(i) * RpmNum) / RpmDen);
			end else begin
				t[i] = '0;
			end
		end
		return t;
	endfunction

	localparam rpm_table_t RpmTable = build_rpm_table();

endpackage

`default_nettype wire

[hw/rtl/csc_update.sv]
// Per-tick next-state and result logic of the cruise setpoint controller.
`default_nettype none

module csc_update (
	input  csc_pkg::csc_in_t     item,
	input  csc_pkg::csc_state_t  cur,
	input  csc_pkg::csc_cfg_t    cfg,
	output csc_pkg::csc_state_t  nxt,
	output csc_pkg::csc_result_t res
);
	import csc_pkg::*;

	logic [16:0]          pedal_prod;
	logic [17:0]          pedal_sum;
	logic [SetpointW-1:0] pedal_speed;
	logic signed [8:0]    v;
	logic signed [8:0]    step_s;
	logic [SetpointW-1:0] sp_sat;
	logic [TimeW-1:0]     elapsed;
	logic                 send;

	// Pedal speed: sample*120/1023, dividing by 1023 as (x + x/1024 + 1)/1024.
	assign pedal_prod  = 17'(item.pedal_sample) * 17'(SpeedMax);
	assign pedal_sum   = 18'(pedal_prod) + 18'(pedal_prod >> 10) + 18'd1;
	assign pedal_speed = SetpointW'(pedal_sum >> 10);

	assign step_s = $signed({4'b0000, cfg.speed_step});

	// Button edges, brake handling and setpoint steering.
	always_comb begin
		nxt = cur;
		v   = $signed({2'b00, cur.setpoint});
		if (cur.brake_prev && !item.brake_pressed) begin
			nxt.brake_latched = 1'b0;
			v = $signed({2'b00, pedal_speed});
		end
		if (!item.brake_pressed) begin
			if (item.cruise_button && !cur.cruise_prev) begin
				nxt.cruise_on = ~cur.cruise_on;
			end
			nxt.cruise_prev = item.cruise_button;
			if (nxt.cruise_on) begin
				if (item.plus_button && !cur.plus_prev) begin
					v = v + step_s;
				end
				nxt.plus_prev = item.plus_button;
				if (item.minus_button && !cur.minus_prev) begin
					v = v - step_s;
				end
				nxt.minus_prev = item.minus_button;
			end else begin
				v = $signed({2'b00, pedal_speed});
			end
		end else begin
			nxt.brake_latched = 1'b1;
			nxt.cruise_on     = 1'b0;
			v = '0;
		end

		// Clamp the setpoint to the legal speed range.
		if (v < 0) begin
			sp_sat = '0;
		end else if (v > 9'(SpeedMax)) begin
			sp_sat = SetpointW'(SpeedMax);
		end else begin
			sp_sat = v[SetpointW-1:0];
		end
		nxt.setpoint   = sp_sat;
		nxt.brake_prev = item.brake_pressed;
		if (send) begin
			nxt.last_send_ms = item.now_ms;
		end
	end

	// Frame timer: wrapped elapsed time strictly past the interval.
	assign elapsed = item.now_ms - cur.last_send_ms;
	assign send    = elapsed > {16'h0000, cfg.send_interval_ms};

	// Result fields; frame fields are zero when no frame goes out.
	always_comb begin
		res.cruise_lamp  = nxt.cruise_on;
		res.brake_lamp   = item.brake_pressed;
		res.send_frame   = send;
		res.frame_rpm    = send ? RpmTable[sp_sat] : '0;
		res.frame_cruise = send & nxt.cruise_on;
		res.frame_brake  = send & nxt.brake_latched;
	end

endmodule

`default_nettype wire

[hw/rtl/cruise_setpoint_controller.sv]
// Top level of the cruise setpoint controller: handshake, registers and state.
//
// Usage: each input beat on the s_ group is one control tick (pedal sample,
// brake and button levels, millisecond time). Every tick yields exactly one
// result beat on the m_ group: lamps, a send flag in m_tuser and the frame
// fields (rpm, cruise and brake flags), which are zero when no frame is sent.
// An accepted input beat goes into the input register and then into the
// result register, which drives m_. Throughput is one beat per cycle while
// m_tready stays high; the tick logic is a single registered pass between the two.
// When m_tready is low the result register holds and the input register still
// takes one more beat; s_tready then drops until the result is taken.
// Configuration writes through cfg_wen/cfg_index/cfg_wdata take effect at once
// and are meant to happen only while no beat is in flight.
// Reset (arst_n low) empties both registers, clears all controller state and
// loads the send interval with 50 ms and the speed step with 5.
`default_nettype none

module cruise_setpoint_controller (
	input  wire                               clk,
	input  wire                               arst_n,
	// Configuration write port.
	input  wire                               cfg_wen,
	input  wire  [csc_pkg::CfgIndexW-1:0]     cfg_index,
	input  wire  [csc_pkg::CfgDataW-1:0]      cfg_wdata,
	// Input stream: tdata from bit 0 = pedal_sample[9:0], brake_pressed,
	// cruise_button, plus_button, minus_button, now_ms[31:0], zero pad.
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [csc_pkg::InDataW-1:0]       s_tdata,
	// Output stream: tdata from bit 0 = cruise_lamp, brake_lamp,
	// frame_rpm[10:0], frame_cruise, frame_brake, zero pad.
	// tuser = send_frame.
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [csc_pkg::OutDataW-1:0]      m_tdata,
	output logic                              m_tuser
);
	import csc_pkg::*;

	csc_cfg_t    cfg_q;
	csc_state_t  state_q;
	csc_state_t  state_nxt;
	csc_in_t     in_beat;
	csc_in_t     item_s1;
	logic        valid_s1;
	csc_result_t res_nxt;
	csc_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	assign in_beat = csc_in_t'(s_tdata[45:0]);

	// The input register moves into the result register when that one is empty or being taken.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	csc_update u_update (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.send_interval_ms <= IntervalReset;
			cfg_q.speed_step       <= StepReset;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				RegSendInterval: cfg_q.send_interval_ms <= cfg_wdata;
				RegSpeedStep:    cfg_q.speed_step       <= cfg_wdata[StepW-1:0];
				default: ;
			endcase
		end
	end

	// Valid flags and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_beat;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.send_frame;
	assign m_tdata  = {1'b0, res_q.frame_brake, res_q.frame_cruise, res_q.frame_rpm,
		res_q.brake_lamp, res_q.cruise_lamp};

endmodule

`default_nettype wire

[sim/cruise_setpoint_checker.sv]
// Scoreboard for the cruise setpoint controller: tracks registers, predicts each tick, compares.
`default_nettype none

module cruise_setpoint_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wen,
	input  wire  [csc_pkg::CfgIndexW-1:0] cfg_index,
	input  wire  [csc_pkg::CfgDataW-1:0]  cfg_wdata,
	input  wire                           s_tvalid,
	input  wire                           s_tready,
	// From bit 0: pedal_sample[9:0], brake_pressed, cruise_button, plus_button,
	// minus_button, now_ms[31:0], zero pad.
	input  wire  [csc_pkg::InDataW-1:0]   s_tdata,
	input  wire                           m_tvalid,
	input  wire                           m_tready,
	// From bit 0: cruise_lamp, brake_lamp, frame_rpm[10:0], frame_cruise,
	// frame_brake, zero pad.
	input  wire  [csc_pkg::OutDataW-1:0]  m_tdata,
	// send_frame.
	input  wire                           m_tuser,
	output int                            fail_count,
	output int                            pending,
	output int                            ticks_checked,
	output int                            frames_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	localparam int PedalFull = 1023;
	localparam int ReportLimit = 10;

	// Shadow copy of the registers.
	logic [IntervalW-1:0] send_interval;
	logic [StepW-1:0]     speed_step;

	// Shadow copy of the controller state.
	logic                 brake_prev;
	logic                 cruise_prev;
	logic                 plus_prev;
	logic                 minus_prev;
	logic                 cruise_on;
	logic                 brake_latched;
	logic [SetpointW-1:0] setpoint;
	logic [TimeW-1:0]     last_send_ms;

	csc_result_t expected_ticks[$];

	// Advance the shadow controller by one tick and return the result it must produce.
	function automatic csc_result_t advance_controller(csc_in_t t);
		int pedal_speed;
		int target;
		logic [TimeW-1:0] elapsed;
		longint unsigned rpm;
		csc_result_t r;
		pedal_speed = (int'(t.pedal_sample) * SpeedMax) / PedalFull;
		target = int'(setpoint);

		// Brake release reloads the setpoint from the pedal.
		if (brake_prev && !t.brake_pressed) begin
			brake_latched = 1'b0;
			target = pedal_speed;
		end

		if (!t.brake_pressed) begin
			if (t.cruise_button && !cruise_prev) begin
				cruise_on = !cruise_on;
			end
			cruise_prev = t.cruise_button;
			if (cruise_on) begin
				if (t.plus_button && !plus_prev) begin
					target = target + int'(speed_step);
				end
				plus_prev = t.plus_button;
				if (t.minus_button && !minus_prev) begin
					target = target - int'(speed_step);
				end
				minus_prev = t.minus_button;
			end else begin
				target = pedal_speed;
			end
		end else begin
			brake_latched = 1'b1;
			cruise_on = 1'b0;
			target = 0;
		end

		// Saturate to the legal speed range.
		if (target < 0) begin
			target = 0;
		end else if (target > SpeedMax) begin
			target = SpeedMax;
		end
		setpoint = SetpointW'(target);
		brake_prev = t.brake_pressed;

		r = '0;
		r.cruise_lamp = cruise_on;
		r.brake_lamp = t.brake_pressed;
		elapsed = t.now_ms - last_send_ms;
		if (elapsed > TimeW'(send_interval)) begin
			last_send_ms = t.now_ms;
			rpm = (longint'(setpoint) * RpmNum) / RpmDen;
			r.send_frame = 1'b1;
			r.frame_rpm = rpm[RpmW-1:0];
			r.frame_cruise = cruise_on;
			r.frame_brake = brake_latched;
		end
		return r;
	endfunction

	// Watch the configuration port and both streams.
	always @(posedge clk or negedge arst_n) begin
		csc_result_t want;
		csc_result_t got;
		if (!arst_n) begin
			send_interval = IntervalReset;
			speed_step = StepReset;
			brake_prev = 1'b0;
			cruise_prev = 1'b0;
			plus_prev = 1'b0;
			minus_prev = 1'b0;
			cruise_on = 1'b0;
			brake_latched = 1'b0;
			setpoint = '0;
			last_send_ms = '0;
			expected_ticks.delete();
			fail_count = 0;
			pending = 0;
			ticks_checked = 0;
			frames_seen = 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == RegSendInterval) begin
					send_interval = cfg_wdata[IntervalW-1:0];
				end else if (cfg_index == RegSpeedStep) begin
					speed_step = cfg_wdata[StepW-1:0];
				end
			end

			if (s_tvalid && s_tready) begin
				expected_ticks.push_back(advance_controller(csc_in_t'(s_tdata[$bits(csc_in_t)-1:0])));
			end

			// Unpack the result beat and compare it with the oldest prediction.
			if (m_tvalid && m_tready) begin
				got = '0;
				got.cruise_lamp = m_tdata[0];
				got.brake_lamp = m_tdata[1];
				got.frame_rpm = m_tdata[RpmW+1:2];
				got.frame_cruise = m_tdata[RpmW+2];
				got.frame_brake = m_tdata[RpmW+3];
				got.send_frame = m_tuser;
				if (got.send_frame) begin
					frames_seen++;
				end
				if (expected_ticks.size() == 0) begin
					fail_count++;
					if (fail_count <= ReportLimit) begin
						$display("%t: result beat with no tick waiting", $realtime);
					end
				end else begin
					want = expected_ticks.pop_front();
					ticks_checked++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= ReportLimit) begin
							$display("%t: tick %0d mismatch", $realtime, ticks_checked);
							$display("  expected cruise=%0d brake=%0d send=%0d rpm=%0d fcruise=%0d fbrake=%0d",
								want.cruise_lamp, want.brake_lamp, want.send_frame,
								want.frame_rpm, want.frame_cruise, want.frame_brake);
							$display("  actual   cruise=%0d brake=%0d send=%0d rpm=%0d fcruise=%0d fbrake=%0d",
								got.cruise_lamp, got.brake_lamp, got.send_frame,
								got.frame_rpm, got.frame_cruise, got.frame_brake);
						end
					end
				end
			end
			pending = expected_ticks.size();
		end
	end

endmodule

`default_nettype wire

[sim/cruise_setpoint_controller_tb.sv]
// Testbench top for the cruise setpoint controller: clock, reset, stimulus and verdict.
`default_nettype none

module cruise_setpoint_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	localparam int StallLimit = 2000;
	localparam int PhaseTicks = 175;
	localparam int SettleCycles = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutDataW-1:0]  m_tdata;
	logic                 m_tuser;

	int fail_count;
	int pending;
	int ticks_checked;
	int frames_seen;
	int stall_cycles = 0;
	int settings_used = 0;

	// Stimulus state: no idling while steady is set.
	logic        steady = 1'b0;
	int          cur_interval = 50;
	logic [31:0] clock_ms = '0;
	logic [9:0]  pedal_level = '0;
	logic        brake_level = 1'b0;
	logic        cruise_level = 1'b0;
	logic        plus_level = 1'b0;
	logic        minus_level = 1'b0;

	cruise_setpoint_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	cruise_setpoint_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.ticks_checked (ticks_checked),
		.frames_seen   (frames_seen)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 6);
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= StallLimit) begin
			$display("watchdog: no beat accepted for %0d cycles", StallLimit);
			$display("tb: failure");
			$finish;
		end
	end

	// Present one tick and hold it until the block takes the beat.
	task automatic drive_tick(input logic [9:0] pedal, input logic brake, input logic cbtn,
			input logic pbtn, input logic mbtn, input logic [31:0] now);
		csc_in_t t;
		t.pedal_sample = pedal;
		t.brake_pressed = brake;
		t.cruise_button = cbtn;
		t.plus_button = pbtn;
		t.minus_button = mbtn;
		t.now_ms = now;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(t);
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Wait for the block to drain, then load both registers.
	task automatic load_registers(input logic [15:0] interval, input logic [15:0] step);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (SettleCycles) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= RegSendInterval;
		cfg_wdata <= interval;
		@(negedge clk);
		cfg_index <= RegSpeedStep;
		cfg_wdata <= step;
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_interval = int'(interval);
		settings_used++;
	endtask

	// A stretch of driving: held buttons with occasional presses, mostly advancing time,
	// and a share of scrambled ticks.
	task automatic drive_session(input int count);
		int walk;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 8) begin
				pedal_level = 10'($urandom);
				brake_level = 1'($urandom);
				cruise_level = 1'($urandom);
				plus_level = 1'($urandom);
				minus_level = 1'($urandom);
				clock_ms = ($urandom_range(1) == 0) ? $urandom : clock_ms + $urandom_range(0, 80);
			end else begin
				if ($urandom_range(99) < 6) brake_level = !brake_level;
				if ($urandom_range(99) < 15) cruise_level = !cruise_level;
				if ($urandom_range(99) < 30) plus_level = !plus_level;
				if ($urandom_range(99) < 30) minus_level = !minus_level;
				case ($urandom_range(9))
					0: pedal_level = ($urandom_range(1) == 0) ? 10'd0 : 10'd1023;
					1, 2, 3, 4: pedal_level = 10'($urandom);
					default: begin
						walk = int'(pedal_level) + $urandom_range(0, 40) - 20;
						if (walk < 0) walk = 0;
						if (walk > 1023) walk = 1023;
						pedal_level = 10'(walk);
					end
				endcase
				case ($urandom_range(99))
					0, 1, 2: clock_ms = $urandom;
					3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14:
						clock_ms = clock_ms + $urandom_range(0, 2 * cur_interval + 2);
					default: clock_ms = clock_ms + $urandom_range(0, 25);
				endcase
			end
			drive_tick(pedal_level, brake_level, cruise_level, plus_level, minus_level,
				clock_ms);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset settings (send after 50 ms, step 5).
		drive_tick(10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		// Full pedal, first frame at top speed.
		drive_tick(10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, 32'd51);
		// Plus pressed out of cruise: ignored and not remembered.
		drive_tick(10'd1023, 1'b0, 1'b0, 1'b1, 1'b0, 32'd60);
		// Cruise engages and plus counts as a fresh press; setpoint saturates high.
		drive_tick(10'd512,  1'b0, 1'b1, 1'b1, 1'b0, 32'd70);
		drive_tick(10'd512,  1'b0, 1'b1, 1'b0, 1'b0, 32'd80);
		drive_tick(10'd512,  1'b0, 1'b0, 1'b1, 1'b0, 32'd90);
		drive_tick(10'd512,  1'b0, 1'b0, 1'b1, 1'b1, 32'd200);
		drive_tick(10'd512,  1'b0, 1'b0, 1'b0, 1'b0, 32'd210);
		// Plus and minus pressed together.
		drive_tick(10'd1023, 1'b0, 1'b0, 1'b1, 1'b1, 32'd220);
		drive_tick(10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, 32'd230);
		// Brake with cruise pressed: cruise drops, flag latches, button memories freeze.
		drive_tick(10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, 32'd300);
		drive_tick(10'd700,  1'b1, 1'b0, 1'b1, 1'b1, 32'd310);
		drive_tick(10'd700,  1'b1, 1'b1, 1'b0, 1'b0, 32'd400);
		// Brake release reloads from the pedal; held cruise button now counts as an edge.
		drive_tick(10'd300,  1'b0, 1'b1, 1'b0, 1'b0, 32'd410);
		drive_tick(10'd300,  1'b0, 1'b0, 1'b0, 1'b1, 32'd420);
		// Time wrapping past the top of the counter.
		drive_tick(10'd300,  1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);
		drive_tick(10'd300,  1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0020);
		drive_tick(10'd300,  1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0023);
		drive_tick(10'd0,    1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0400);
		drive_tick(10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		clock_ms = 32'hFFFF_FFFF;

		// Random driving under a series of register settings, extremes included.
		load_registers(16'd0, 16'd1);
		drive_session(PhaseTicks);
		load_registers(16'd65535, 16'd30);
		drive_session(PhaseTicks);
		load_registers(16'd50, 16'd31);
		drive_session(PhaseTicks);
		load_registers(16'($urandom_range(0, 300)), 16'd0);
		drive_session(PhaseTicks);
		load_registers(16'd20, 16'($urandom_range(1, 30)));
		drive_session(PhaseTicks);
		steady = 1'b1;
		load_registers(16'($urandom_range(0, 200)), 16'd30);
		drive_session(PhaseTicks);
		steady = 1'b0;
		load_registers(16'd0, 16'd5);
		drive_session(PhaseTicks);
		load_registers(16'($urandom), 16'($urandom_range(0, 31)));
		drive_session(PhaseTicks);

		// Drain and settle.
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (SettleCycles) @(posedge clk);

		$display("summary: %0d ticks checked, %0d frames sent, %0d register settings",
			ticks_checked, frames_seen, settings_used + 1);
		$display("summary: brake, cruise, step saturation and time wrap exercised");
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
